/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	// Results caused by one input word; data[0] goes out first.
	typedef struct packed {
		kind_t           kind;
		logic [2:0]      cnt;
		logic [3:0][7:0] data;
	} pkt_t;

	localparam int QDEPTH_DEF = 4;

endpackage

/* rtl/jsu_front.sv */
// Front end: parses input bytes and builds at most one result packet per word.
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	input  logic          q_full,
	input  logic [7:0]    in_byte,
	input  logic          end_of_text,
	output logic          push,
	output jsu_pkg::pkt_t push_pkt
);
	import jsu_pkg::*;

	typedef enum logic [7:0] {
		M_IDLE   = 8'b0000_0001,
		M_STR    = 8'b0000_0010,
		M_ESC    = 8'b0000_0100,
		M_HEX1   = 8'b0000_1000,
		M_WANTBS = 8'b0001_0000,
		M_WANTU  = 8'b0010_0000,
		M_HEX2   = 8'b0100_0000,
		M_UTF8   = 8'b1000_0000
	} mode_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	function automatic pkt_t encode(input logic [20:0] cp);
		pkt_t p;
		p      = '0;
		p.kind = KIND_BYTE;
		if (cp <= 21'h7f) begin
			p.cnt     = 3'd1;
			p.data[0] = cp[7:0];
		end else if (cp <= 21'h7ff) begin
			p.cnt     = 3'd2;
			p.data[0] = {3'b110, cp[10:6]};
			p.data[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hffff) begin
			p.cnt     = 3'd3;
			p.data[0] = {4'b1110, cp[15:12]};
			p.data[1] = {2'b10, cp[11:6]};
			p.data[2] = {2'b10, cp[5:0]};
		end else begin
			p.cnt     = 3'd4;
			p.data[0] = {5'b11110, cp[20:18]};
			p.data[1] = {2'b10, cp[17:12]};
			p.data[2] = {2'b10, cp[11:6]};
			p.data[3] = {2'b10, cp[5:0]};
		end
		return p;
	endfunction

	mode_t       mode_q, mode_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [9:0]  hs_q, hs_d;
	logic [20:0] code_q, code_d;
	logic [1:0]  urem_q, urem_d;
	logic [1:0]  ulast_q, ulast_d;
	logic [7:0]  raw_q [3];

	logic        accept;
	logic        err;
	logic        hex_ok;
	logic [3:0]  hex_dig;
	logic [15:0] hv_new;
	logic [20:0] code_new;
	logic [10:0] pair_hi;
	logic [20:0] enc_cp;
	logic        enc_bad;
	logic        raw_we;
	logic [1:0]  raw_widx;
	pkt_t        pkt;

	assign accept = byte_valid && !q_full;
	assign push   = accept && (pkt.cnt != 3'd0);
	assign push_pkt = pkt;

	always_comb begin
		hex_ok  = 1'b1;
		hex_dig = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_dig = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_dig = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_dig = 4'(in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign hv_new   = {hex_q[11:0], hex_dig};
	assign code_new = {code_q[14:0], in_byte[5:0]};
	// Surrogate pair: 0x10000 + (high << 10) + low folds into the upper bits.
	assign pair_hi  = {1'b0, hs_q} + 11'd64;
	assign enc_cp   = (mode_q == M_HEX2) ? {pair_hi, hv_new[9:0]} : {5'd0, hv_new};
	assign raw_widx = ulast_q - urem_q + 2'd1;

	always_comb begin
		enc_bad = (code_new > 21'h10ffff)
			|| (code_new >= 21'h00d800 && code_new <= 21'h00dfff);
		case (ulast_q)
			2'd1:    enc_bad = enc_bad || (code_new < 21'h80);
			2'd2:    enc_bad = enc_bad || (code_new < 21'h800);
			default: enc_bad = enc_bad || (code_new < 21'h10000);
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		hex_d   = hex_q;
		hcnt_d  = hcnt_q;
		hs_d    = hs_q;
		code_d  = code_q;
		urem_d  = urem_q;
		ulast_d = ulast_q;
		raw_we  = 1'b0;
		err     = 1'b0;
		pkt      = '0;
		pkt.kind = KIND_BYTE;

		if (end_of_text) begin
			err = 1'b1;
		end else begin
			case (mode_q)
				M_STR: begin
					if (in_byte == CH_QUOTE) begin
						pkt.kind = KIND_CLOSE;
						pkt.cnt  = 3'd1;
						mode_d   = M_IDLE;
					end else if (in_byte < 8'h20) begin
						err = 1'b1;
					end else if (in_byte == CH_BSLASH) begin
						mode_d = M_ESC;
					end else if (in_byte < 8'h80) begin
						pkt.cnt     = 3'd1;
						pkt.data[0] = in_byte;
					end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
						ulast_d = 2'd1;
						urem_d  = 2'd1;
						code_d  = {16'd0, in_byte[4:0]};
						mode_d  = M_UTF8;
					end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
						ulast_d = 2'd2;
						urem_d  = 2'd2;
						code_d  = {17'd0, in_byte[3:0]};
						mode_d  = M_UTF8;
					end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
						ulast_d = 2'd3;
						urem_d  = 2'd3;
						code_d  = {18'd0, in_byte[2:0]};
						mode_d  = M_UTF8;
					end else begin
						err = 1'b1;
					end
				end
				M_ESC: begin
					mode_d  = M_STR;
					pkt.cnt = 3'd1;
					case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: pkt.data[0] = in_byte;
						CH_B: pkt.data[0] = 8'h08;
						CH_F: pkt.data[0] = 8'h0c;
						CH_N: pkt.data[0] = 8'h0a;
						CH_R: pkt.data[0] = 8'h0d;
						CH_T: pkt.data[0] = 8'h09;
						CH_U: begin
							pkt.cnt = 3'd0;
							mode_d  = M_HEX1;
							hex_d   = 16'd0;
							hcnt_d  = 2'd0;
						end
						default: err = 1'b1;
					endcase
				end
				M_HEX1, M_HEX2: begin
					if (!hex_ok) begin
						err = 1'b1;
					end else if (hcnt_q != 2'd3) begin
						hex_d  = hv_new;
						hcnt_d = hcnt_q + 2'd1;
					end else begin
						hcnt_d = 2'd0;
						hex_d  = hv_new;
						if (mode_q == M_HEX1 && hv_new[15:10] == 6'b110110) begin
							hs_d   = hv_new[9:0];
							hex_d  = 16'd0;
							mode_d = M_WANTBS;
						end else if ((mode_q == M_HEX1) == (hv_new[15:10] == 6'b110111)) begin
							// low surrogate first, or second escape not a low surrogate
							err = 1'b1;
						end else begin
							mode_d = M_STR;
							pkt    = encode(enc_cp);
						end
					end
				end
				M_WANTBS: begin
					if (in_byte == CH_BSLASH) mode_d = M_WANTU;
					else err = 1'b1;
				end
				M_WANTU: begin
					if (in_byte == CH_U) begin
						mode_d = M_HEX2;
						hex_d  = 16'd0;
						hcnt_d = 2'd0;
					end else begin
						err = 1'b1;
					end
				end
				M_UTF8: begin
					if (in_byte[7:6] != 2'b10) begin
						err = 1'b1;
					end else if (urem_q > 2'd1) begin
						code_d = code_new;
						raw_we = 1'b1;
						urem_d = urem_q - 2'd1;
					end else if (enc_bad) begin
						err = 1'b1;
					end else begin
						// release the held lead and continuation bytes
						pkt.cnt     = {1'b0, ulast_q} + 3'd1;
						pkt.data[0] = raw_q[0];
						pkt.data[1] = raw_q[1];
						pkt.data[2] = raw_q[2];
						pkt.data[3] = in_byte;
						pkt.data[ulast_q] = in_byte;
						urem_d  = 2'd0;
						code_d  = 21'd0;
						mode_d  = M_STR;
					end
				end
				default: begin
					if (in_byte == CH_QUOTE) mode_d = M_STR;
					else err = 1'b1;
				end
			endcase
		end

		if (err) begin
			pkt      = '0;
			pkt.kind = KIND_ERR;
			pkt.cnt  = 3'd1;
			mode_d   = M_IDLE;
			raw_we   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			hex_q   <= '0;
			hcnt_q  <= '0;
			hs_q    <= '0;
			code_q  <= '0;
			urem_q  <= '0;
			ulast_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			hex_q   <= hex_d;
			hcnt_q  <= hcnt_d;
			hs_q    <= hs_d;
			code_q  <= code_d;
			urem_q  <= urem_d;
			ulast_q <= ulast_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode_q == M_STR && mode_d == M_UTF8) begin
			raw_q[0] <= in_byte;
		end
		if (accept && raw_we) begin
			raw_q[raw_widx] <= in_byte;
		end
	end

endmodule

/* rtl/jsu_queue.sv */
// Packet queue between the parser front end and the result back end.
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QDEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::pkt_t push_pkt,
	input  logic          pop,
	output jsu_pkg::pkt_t head_pkt,
	output logic          full,
	output logic          empty
);
	import jsu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pkt_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_pkt = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)  rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_pkt;
	end

endmodule

/* rtl/jsu_back.sv */
// Back end: unpacks queued packets into single result words.
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::pkt_t head_pkt,
	input  logic          empty,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [1:0]    kind,
	output logic [7:0]    out_byte,
	output logic          last
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load   = !valid_q || !res_stall;
	assign at_end = ({1'b0, idx_q} == head_pkt.cnt - 3'd1);
	assign pop    = load && !empty && at_end;

	assign res_valid = valid_q;
	assign kind      = kind_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			kind_q <= head_pkt.kind;
			byte_q <= head_pkt.data[idx_q];
			last_q <= at_end;
		end
	end

endmodule

/* rtl/json_string_unescape_utf8_top.sv */
// Top level of the streaming JSON string unescaper with UTF-8 checking.
//
// Input channel: byte_valid / byte_stall carry in_byte and end_of_text, one
// word per cycle when byte_stall is low. A quote opens a string; escapes are
// decoded, \u escapes re-encoded as UTF-8, raw UTF-8 checked and passed on.
// Output channel: res_valid / res_stall carry kind, out_byte and last. Each
// input word gives zero to four results; last marks the final one of them.
// A close or error result returns the parser to idle.
// A result passes through a packet queue slot and then the output register
// after its input word is taken.
// Throughput: one input word per cycle while byte_stall is low and one result
// per cycle while res_stall is low; the parser decides each word combinationally
// and the back end unpacks multi-byte packets one byte a cycle, so bursts of up
// to four bytes drain from the QDEPTH-entry packet queue.
// Reset (arst_n low) empties the queue and output register and puts the
// parser in idle, waiting for an opening quote.
// While res_stall is high the output word holds; byte_stall rises only when
// the packet queue is full.
module json_string_unescape_utf8_top #(
	parameter int QDEPTH = jsu_pkg::QDEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       last
);
	import jsu_pkg::*;

	pkt_t push_pkt, head_pkt;
	logic push, pop, q_full, q_empty;

	assign byte_stall = q_full;

	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.q_full      (q_full),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.push_pkt    (push_pkt)
	);

	jsu_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.head_pkt (head_pkt),
		.full     (q_full),
		.empty    (q_empty)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_pkt  (head_pkt),
		.empty     (q_empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

/* rtl/jsu_checker.sv */
// Port-level checker for the unescaper top level, with its bind.
`include "assert_macros.svh"

module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic       last
);
	import jsu_pkg::*;

	`JSU_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(kind) && $stable(out_byte) && $stable(last),
		"stalled result word changed")

	`JSU_ASSERT_IMP(a_marker_alone, clk, arst_n, res_valid && kind != KIND_BYTE,
		last && out_byte == 8'd0, "close or error word not a lone last word")

	`JSU_ASSERT_NXT(a_burst_cont, clk, arst_n, res_valid && !res_stall && !last,
		res_valid && kind == KIND_BYTE, "byte burst broken before its last word")

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.kind      (kind),
	.out_byte  (out_byte),
	.last      (last)
);
